// File: hw/rtl/jet_pkg.sv
// jet_pkg: shared types, widths and constants of the Julia escape-time block.
// No dependencies; used by every module under hw/rtl.
package jet_pkg;

  // Number format and counter width
  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 8;
  localparam int DATA_W     = 32;

  // Magnitude of a component that is at most 2, and its square / sum of squares
  localparam int MAG_W  = FRAC_BITS + 2;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SUM_W  = PROD_W + 1;

  // Running z component: update result (up to 4) plus a full 32-bit c
  localparam int Z_W = ((FRAC_BITS + 3 > DATA_W) ? FRAC_BITS + 3 : DATA_W) + 2;

  // 2 at the component scale, 4 at the squared scale
  localparam logic signed [Z_W-1:0] TWO_Q   = Z_W'(2) << FRAC_BITS;
  localparam logic [SUM_W-1:0]      FOUR_SQ = SUM_W'(1) << (2 * FRAC_BITS + 2);

  // APB register map: word index = paddr[ADDR_W-1:2]
  localparam int ADDR_W = 4;
  typedef logic [ADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_C_REAL   = reg_idx_t'(0);
  localparam reg_idx_t REG_C_IMAG   = reg_idx_t'(1);
  localparam reg_idx_t REG_MAX_ITER = reg_idx_t'(2);

  localparam logic [COUNT_BITS-1:0] MAX_ITER_RST = {COUNT_BITS{1'b1}};

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_CMP,
    ST_UPD
  } state_t;

  // Configuration seen by the core
  typedef struct packed {
    logic signed [DATA_W-1:0] c_real;
    logic signed [DATA_W-1:0] c_imag;
    logic [COUNT_BITS-1:0]    max_iterations;
  } cfg_t;

endpackage

// File: hw/rtl/julia_escape_time.sv
// Julia escape-time unit, top level: APB registers, sequencer, shared multiplier.
// Flow: each iteration steps through SQX, SQY, CMP and UPD; a point ends in SQX or CMP,
//   with N = max_iterations (255 at most) as the iteration limit.
// Points: one at a time, a new word taken in the strobe cycle; the shared
//   multiplier runs x*x, y*y, x*y in turn.
// Reset (rst_n, synchronous, active low): idle, c = 0, max_iterations = 255.
// The result word is on the out_ ports for exactly one cycle; no back-pressure.
module julia_escape_time (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jet_pkg::ADDR_W-1:0]         paddr,
  input  logic [jet_pkg::DATA_W-1:0]         pwdata,
  output logic [jet_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [jet_pkg::DATA_W-1:0]  in_start_real,
  input  logic signed [jet_pkg::DATA_W-1:0]  in_start_imag,
  output logic                               out_valid,
  output logic [jet_pkg::COUNT_BITS-1:0]     out_escape_count
);

  jet_pkg::cfg_t               cfg;
  logic [jet_pkg::MAG_W-1:0]   op_a, op_b;
  logic [jet_pkg::PROD_W-1:0]  prod;

  // Configuration registers
  jet_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Shared multiplier
  jet_mult u_mult (
    .clk    (clk),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // Iteration sequencer
  jet_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .start_i      (start),
    .start_real_i (in_start_real),
    .start_imag_i (in_start_imag),
    .busy_o       (busy),
    .op_a_o       (op_a),
    .op_b_o       (op_b),
    .prod_i       (prod),
    .out_valid_o  (out_valid),
    .out_count_o  (out_escape_count)
  );

`ifndef SYNTH
  // An accepted word keeps the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the unit busy");

  // A result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

  // The count never exceeds the limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_escape_count <= cfg.max_iterations))
    else $error("escape count above iteration limit");
`endif

endmodule

// File: hw/rtl/jet_cfg.sv
// jet_cfg: APB register bank holding c and the iteration limit.
// Depends on jet_pkg.
module jet_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jet_pkg::ADDR_W-1:0]      paddr,
  input  logic [jet_pkg::DATA_W-1:0]      pwdata,
  output logic [jet_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  output jet_pkg::cfg_t                   cfg_o
);

  jet_pkg::cfg_t    cfg_r;
  jet_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[jet_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_r;

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real         <= '0;
      cfg_r.c_imag         <= '0;
      cfg_r.max_iterations <= jet_pkg::MAX_ITER_RST;
    end else if (wr_en) begin
      case (idx)
        jet_pkg::REG_C_REAL:   cfg_r.c_real         <= pwdata;
        jet_pkg::REG_C_IMAG:   cfg_r.c_imag         <= pwdata;
        jet_pkg::REG_MAX_ITER: cfg_r.max_iterations <= pwdata[jet_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (idx)
      jet_pkg::REG_C_REAL:   prdata = cfg_r.c_real;
      jet_pkg::REG_C_IMAG:   prdata = cfg_r.c_imag;
      jet_pkg::REG_MAX_ITER: prdata = jet_pkg::DATA_W'(cfg_r.max_iterations);
      default:               prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/jet_mult.sv
// jet_mult: the shared unsigned multiplier with a registered product.
// Depends on jet_pkg; used for x*x, y*y and x*y in turn.
module jet_mult (
  input  logic                         clk,
  input  logic [jet_pkg::MAG_W-1:0]    op_a_i,
  input  logic [jet_pkg::MAG_W-1:0]    op_b_i,
  output logic [jet_pkg::PROD_W-1:0]   prod_o
);

  logic [jet_pkg::PROD_W-1:0] prod_r;

  // One product per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= jet_pkg::PROD_W'(op_a_i) * jet_pkg::PROD_W'(op_b_i);
  end

  assign prod_o = prod_r;

endmodule

// File: hw/rtl/jet_seq.sv
// jet_seq: sequencer and z datapath; drives the shared multiplier, tests |z|^2
// against 4 and counts iterations. Depends on jet_pkg.
module jet_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  jet_pkg::cfg_t                      cfg_i,
  input  logic                               start_i,
  input  logic signed [jet_pkg::DATA_W-1:0]  start_real_i,
  input  logic signed [jet_pkg::DATA_W-1:0]  start_imag_i,
  output logic                               busy_o,
  output logic [jet_pkg::MAG_W-1:0]          op_a_o,
  output logic [jet_pkg::MAG_W-1:0]          op_b_o,
  input  logic [jet_pkg::PROD_W-1:0]         prod_i,
  output logic                               out_valid_o,
  output logic [jet_pkg::COUNT_BITS-1:0]     out_count_o
);

  jet_pkg::state_t state_r, state_nxt;

  logic signed [jet_pkg::Z_W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [jet_pkg::PROD_W-1:0]        sx_r, sx_nxt, sy_r, sy_nxt;
  logic [jet_pkg::COUNT_BITS-1:0]    count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [jet_pkg::COUNT_BITS-1:0]    out_count_r, out_count_nxt;

  logic signed [jet_pkg::Z_W-1:0]    ax_full, ay_full;
  logic [jet_pkg::MAG_W-1:0]         ax, ay;
  logic                              big, at_limit, sq_gt, sq_lt, neg_xy;
  logic [jet_pkg::SUM_W-1:0]         sq_sum;
  logic signed [jet_pkg::SUM_W-1:0]  re_diff, im_prod;
  logic signed [jet_pkg::Z_W-1:0]    nx, ny;

  // Magnitudes; only used once both components are known to be within 2
  assign ax_full = x_r[jet_pkg::Z_W-1] ? -x_r : x_r;
  assign ay_full = y_r[jet_pkg::Z_W-1] ? -y_r : y_r;
  assign ax      = ax_full[jet_pkg::MAG_W-1:0];
  assign ay      = ay_full[jet_pkg::MAG_W-1:0];

  // A component beyond 2 already means |z|^2 > 4
  assign big = (x_r > jet_pkg::TWO_Q) || (x_r < -jet_pkg::TWO_Q) ||
               (y_r > jet_pkg::TWO_Q) || (y_r < -jet_pkg::TWO_Q);
  assign at_limit = (count_r == cfg_i.max_iterations);

  // Exact |z|^2 test; y^2 is still on the multiplier output in ST_CMP
  assign sq_sum = jet_pkg::SUM_W'(sx_r) + jet_pkg::SUM_W'(prod_i);
  assign sq_gt  = sq_sum > jet_pkg::FOUR_SQ;
  assign sq_lt  = sq_sum < jet_pkg::FOUR_SQ;

  // Update: floor((x^2 - y^2) / 2^F) and floor(2xy / 2^F)
  assign neg_xy  = x_r[jet_pkg::Z_W-1] ^ y_r[jet_pkg::Z_W-1];
  assign re_diff = $signed(jet_pkg::SUM_W'(sx_r)) - $signed(jet_pkg::SUM_W'(sy_r));
  assign im_prod = neg_xy ? -$signed(jet_pkg::SUM_W'(prod_i))
                          :  $signed(jet_pkg::SUM_W'(prod_i));
  assign nx = jet_pkg::Z_W'(re_diff >>> jet_pkg::FRAC_BITS);
  assign ny = jet_pkg::Z_W'(im_prod >>> (jet_pkg::FRAC_BITS - 1));

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jet_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    out_count_r <= out_count_nxt;
  end

  // Sequencer: SQX -> SQY -> CMP -> UPD per iteration
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    op_a_o        = ax;
    op_b_o        = ax;

    case (state_r)
      jet_pkg::ST_IDLE: begin
        if (start_i) begin
          x_nxt     = jet_pkg::Z_W'(start_real_i);
          y_nxt     = jet_pkg::Z_W'(start_imag_i);
          count_nxt = '0;
          state_nxt = jet_pkg::ST_SQX;
        end
      end
      jet_pkg::ST_SQX: begin
        // x^2 issued; escape early on a component beyond 2
        if (big) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = jet_pkg::ST_IDLE;
        end else begin
          state_nxt = jet_pkg::ST_SQY;
        end
      end
      jet_pkg::ST_SQY: begin
        op_a_o    = ay;
        op_b_o    = ay;
        sx_nxt    = prod_i;
        state_nxt = jet_pkg::ST_CMP;
      end
      jet_pkg::ST_CMP: begin
        // x*y issued while the sum of squares is tested
        op_a_o = ax;
        op_b_o = ay;
        sy_nxt = prod_i;
        if (at_limit) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = sq_lt ? '0 : count_r;
          state_nxt     = jet_pkg::ST_IDLE;
        end else if (sq_gt) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = jet_pkg::ST_IDLE;
        end else begin
          state_nxt = jet_pkg::ST_UPD;
        end
      end
      jet_pkg::ST_UPD: begin
        x_nxt     = nx + jet_pkg::Z_W'($signed(cfg_i.c_real));
        y_nxt     = ny + jet_pkg::Z_W'($signed(cfg_i.c_imag));
        count_nxt = count_r + jet_pkg::COUNT_BITS'(1);
        state_nxt = jet_pkg::ST_SQX;
      end
      default: begin
        state_nxt = jet_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_r != jet_pkg::ST_IDLE);
  assign out_valid_o = out_valid_r;
  assign out_count_o = out_count_r;

endmodule

// File: bench/tb_julia_escape_time.sv
// Self-checking bench for julia_escape_time: drives start points and APB register writes,
// predicts each escape count in 128-bit fixed point and checks every result word.
// Depends on jet_pkg and julia_escape_time (hw/rtl).
module tb_julia_escape_time;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC_BITS    = jet_pkg::FRAC_BITS;
  localparam int          COUNT_BITS   = jet_pkg::COUNT_BITS;
  localparam int          DATA_W       = jet_pkg::DATA_W;
  localparam int          ADDR_W       = jet_pkg::ADDR_W;
  localparam int          ONE_Q        = 1 << FRAC_BITS;
  localparam int          CYCLE_LIMIT  = 8_000_000;
  localparam int          TAIL_CYCLES  = 4 * 255 + 80;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_POINTS = 160;
  localparam logic signed [127:0] TWO_WIDE  = 128'sd2 <<< FRAC_BITS;
  localparam logic signed [127:0] FOUR_WIDE = 128'sd1 <<< (2 * FRAC_BITS + 2);

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } point_t;

  typedef struct packed {
    point_t                z0;
    logic [COUNT_BITS-1:0] count;
  } count_word_t;

  // DUT signals, all inputs known from time zero
  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ADDR_W-1:0]           paddr = '0;
  logic [DATA_W-1:0]           pwdata = '0;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;
  logic                        start = 1'b0;
  logic                        busy;
  logic signed [DATA_W-1:0]    in_start_real = '0;
  logic signed [DATA_W-1:0]    in_start_imag = '0;
  logic                        out_valid;
  logic [COUNT_BITS-1:0]       out_escape_count;

  // Bench state
  jet_pkg::cfg_t julia_cfg;
  point_t        pending_points[$];
  count_word_t   expected_counts[$];
  int            failures = 0;
  int            cycles = 0;
  int            gap_left = 0;
  int            burst_left = 1;

  julia_escape_time dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_start_real    (in_start_real),
    .in_start_imag    (in_start_imag),
    .out_valid        (out_valid),
    .out_escape_count (out_escape_count)
  );

  always #5 clk = ~clk;

  // |z|^2 against 4: -1 below, 0 equal, 1 above; a component beyond 2 is above
  function automatic int mag_sq_vs_four(logic signed [127:0] x, logic signed [127:0] y);
    logic signed [127:0] sum;
    if (x > TWO_WIDE || x < -TWO_WIDE || y > TWO_WIDE || y < -TWO_WIDE) return 1;
    sum = x * x + y * y;
    if (sum < FOUR_WIDE) return -1;
    if (sum > FOUR_WIDE) return 1;
    return 0;
  endfunction

  // Escape-time count of one start point under the current register values
  function automatic logic [COUNT_BITS-1:0] julia_escape_count(point_t z0,
                                                               jet_pkg::cfg_t cfg);
    logic signed [127:0] x, y, nx, ny, cr, ci;
    int unsigned         iter;
    x  = $signed(z0.re);
    y  = $signed(z0.im);
    cr = $signed(cfg.c_real);
    ci = $signed(cfg.c_imag);
    // outside the closed square: no iteration at all
    if (x > TWO_WIDE || x < -TWO_WIDE || y > TWO_WIDE || y < -TWO_WIDE) return '0;
    iter = 0;
    while (iter < cfg.max_iterations) begin
      if (mag_sq_vs_four(x, y) > 0) break;
      // arithmetic shift gives floor for both signs
      nx = ((x * x - y * y) >>> FRAC_BITS) + cr;
      ny = (((x * y) <<< 1) >>> FRAC_BITS) + ci;
      x = nx;
      y = ny;
      iter++;
    end
    if (iter < cfg.max_iterations) return COUNT_BITS'(iter);
    if (mag_sq_vs_four(x, y) < 0) return '0;
    return COUNT_BITS'(iter);
  endfunction

  // Coordinate: mostly inside the square, some on or just past its border, some any word
  function automatic logic signed [DATA_W-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q;
    if (pick < 80) return int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
    if (pick < 90) begin
      case ($urandom_range(0, 4))
        0: return 2 * ONE_Q;
        1: return -2 * ONE_Q;
        2: return 2 * ONE_Q + 1;
        3: return -2 * ONE_Q - 1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // Julia constant: mostly within [-2,2], some up to +-4, a few arbitrary words
  function automatic logic [DATA_W-1:0] rand_c();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q;
    if (pick < 90) return DATA_W'($urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
    return $urandom;
  endfunction

  // APB write: setup then access, register updates when pready is seen
  task automatic write_julia_cfg(input jet_pkg::reg_idx_t idx,
                                 input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      jet_pkg::REG_C_REAL:   julia_cfg.c_real = value;
      jet_pkg::REG_C_IMAG:   julia_cfg.c_imag = value;
      jet_pkg::REG_MAX_ITER: julia_cfg.max_iterations = value[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_julia(input logic [DATA_W-1:0] cr, input logic [DATA_W-1:0] ci,
                           input logic [COUNT_BITS-1:0] lim);
    write_julia_cfg(jet_pkg::REG_C_REAL, cr);
    write_julia_cfg(jet_pkg::REG_C_IMAG, ci);
    write_julia_cfg(jet_pkg::REG_MAX_ITER, DATA_W'(lim));
  endtask

  task automatic push_point(input logic signed [DATA_W-1:0] re,
                            input logic signed [DATA_W-1:0] im);
    pending_points.push_back('{re: re, im: im});
  endtask

  // Every result yields a word, so idle means nothing queued, nothing owed, not busy
  task automatic wait_idle();
    while (pending_points.size() != 0 || start || busy || expected_counts.size() != 0)
      @(posedge clk);
  endtask

  // Driver: bursts of start points with random gaps; start held until accepted
  always @(posedge clk) begin
    logic   accepted;
    point_t z0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        z0 = '{re: in_start_real, im: in_start_imag};
        expected_counts.push_back('{z0: z0, count: julia_escape_count(z0, julia_cfg)});
        void'(pending_points.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
      end
      if (!start || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_points.size() != 0) begin
          start         <= 1'b1;
          in_start_real <= pending_points[0].re;
          in_start_imag <= pending_points[0].im;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed word against the oldest prediction
  always @(posedge clk) begin
    count_word_t want;
    if (rst_n && out_valid) begin
      if (expected_counts.size() == 0) begin
        $error("escape_count: unexpected word %0d with nothing outstanding", out_escape_count);
        failures++;
      end else begin
        want = expected_counts.pop_front();
        if (out_escape_count !== want.count) begin
          $error("escape_count mismatch for z0=(%0d,%0d): expected %0d, actual %0d",
                 want.z0.re, want.z0.im, want.count, out_escape_count);
          failures++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    julia_cfg.c_real         = '0;
    julia_cfg.c_imag         = '0;
    julia_cfg.max_iterations = jet_pkg::MAX_ITER_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait_idle();

    // reset values: c = 0, limit 255; origin, border, corners, outside, extremes
    push_point(0, 0);
    push_point(2 * ONE_Q, 0);
    push_point(-2 * ONE_Q, 0);
    push_point(0, 2 * ONE_Q);
    push_point(2 * ONE_Q, 2 * ONE_Q);
    push_point(2 * ONE_Q + 1, 0);
    push_point(0, -2 * ONE_Q - 1);
    push_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    push_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    push_point(ONE_Q, 0);
    push_point(ONE_Q + 1, 0);
    push_point(ONE_Q / 2, -ONE_Q / 2);
    wait_idle();

    // c = 2, limit 1: |z|^2 exactly 4, above 4 and below 4 when the limit is hit
    set_julia(2 * ONE_Q, 0, 1);
    push_point(0, 0);
    push_point(ONE_Q / 2, 0);
    push_point(0, ONE_Q);
    push_point(-ONE_Q, -ONE_Q);
    wait_idle();

    // zero limit with c = -4 + 4i
    set_julia(-4 * ONE_Q, 4 * ONE_Q, 0);
    push_point(0, 0);
    push_point(2 * ONE_Q, -2 * ONE_Q);
    wait_idle();

    // random phases, each with its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_julia(int'($urandom_range(0, 32'd429496729)) - 214748364,
                     int'($urandom_range(0, 32'd429496729)) - 214748364, 8'd255);
        1: set_julia(-4 * ONE_Q, 4 * ONE_Q, COUNT_BITS'($urandom_range(1, 255)));
        2: set_julia(32'h7FFF_FFFF, 32'h8000_0000, COUNT_BITS'($urandom_range(1, 255)));
        default: set_julia(rand_c(), rand_c(), COUNT_BITS'($urandom_range(1, 60)));
      endcase
      for (int i = 0; i < PHASE_POINTS; i++) push_point(rand_coord(), rand_coord());
      wait_idle();
    end

    // let any stray word show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_counts.size() != 0) begin
      $error("escape_count: %0d words never arrived", expected_counts.size());
      failures++;
    end
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
